// File: sv/ttb_pkg.sv
`timescale 1ns / 1ps

package ttb_pkg;

	// Default values of the top-level parameters.
	localparam int TILE_SIZE_DEF        = 16;
	localparam int MAX_TILES_ACROSS_DEF = 8;
	localparam int MAX_TILES_DOWN_DEF   = 8;
	localparam int TRIANGLE_ID_BITS_DEF = 16;

	// Fixed field widths.
	localparam int COORD_W     = 16;
	localparam int SLOT_W      = 6;
	localparam int ID_OUT_W    = 16;
	localparam int CFG_W       = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int IN_TDATA_W  = 6 * COORD_W;
	localparam int OUT_TDATA_W = 24;

	// Configuration register indexes and reset value.
	localparam logic [CFG_INDEX_W-1:0] REG_TILES_ACROSS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TILES_DOWN   = 1'd1;
	localparam logic [CFG_W-1:0]       CFG_RESET        = 4'd8;

	// Command codes carried in tuser.
	localparam logic CMD_BIN   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BOX,
		ST_RANGE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_box;    // capture bounding box of an accepted bin beat
		logic load_range;  // capture clamped tile range
		logic start;       // take a triangle index and load the tile walker
		logic step;        // emit one tile and advance the walker
		logic clear_id;    // return the triangle counter to zero
	} dp_cmd_t;

	typedef struct packed {
		logic skip;        // empty or off-grid box
		logic last;        // walker sits on the final tile
		logic out_free;    // output register can take a beat this cycle
	} dp_status_t;

endpackage

// File: sv/ttb_ctrl.sv
`timescale 1ns / 1ps

module ttb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_command,
	output logic               in_ready,
	input  ttb_pkg::dp_status_t status,
	output ttb_pkg::dp_cmd_t   cmd
);

	ttb_pkg::state_t state_q;
	ttb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ttb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command == ttb_pkg::CMD_CLEAR) begin
						cmd.clear_id = 1'b1;
					end else begin
						cmd.load_box = 1'b1;
						state_d      = ttb_pkg::ST_BOX;
					end
				end
			end
			ttb_pkg::ST_BOX: begin
				cmd.load_range = 1'b1;
				state_d        = ttb_pkg::ST_RANGE;
			end
			ttb_pkg::ST_RANGE: begin
				if (status.skip) begin
					state_d = ttb_pkg::ST_IDLE;
				end else begin
					cmd.start = 1'b1;
					state_d   = ttb_pkg::ST_EMIT;
				end
			end
			ttb_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.last) begin
						state_d = ttb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ttb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/ttb_datapath.sv
`timescale 1ns / 1ps

module ttb_datapath #(
	parameter int TILE_SIZE        = ttb_pkg::TILE_SIZE_DEF,
	parameter int MAX_TILES_ACROSS = ttb_pkg::MAX_TILES_ACROSS_DEF,
	parameter int MAX_TILES_DOWN   = ttb_pkg::MAX_TILES_DOWN_DEF,
	parameter int TRIANGLE_ID_BITS = ttb_pkg::TRIANGLE_ID_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ttb_pkg::dp_cmd_t                   cmd,
	output ttb_pkg::dp_status_t                status,
	input  logic [ttb_pkg::IN_TDATA_W-1:0]     in_data,
	input  logic                               cfg_write,
	input  logic [ttb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ttb_pkg::CFG_W-1:0]          cfg_data,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ttb_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tlast
);

	localparam int MAX_ALL = (MAX_TILES_ACROSS > MAX_TILES_DOWN) ?
		MAX_TILES_ACROSS : MAX_TILES_DOWN;
	localparam int CNT_W = $clog2(MAX_ALL + 1);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [TRIANGLE_ID_BITS-1:0] ID_TOP = '1;
	localparam int PAD_W = ttb_pkg::OUT_TDATA_W - ttb_pkg::SLOT_W - ttb_pkg::ID_OUT_W;

	function automatic logic signed [ttb_pkg::COORD_W-1:0] min3(
		input logic signed [ttb_pkg::COORD_W-1:0] a,
		input logic signed [ttb_pkg::COORD_W-1:0] b,
		input logic signed [ttb_pkg::COORD_W-1:0] c
	);
		logic signed [ttb_pkg::COORD_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [ttb_pkg::COORD_W-1:0] max3(
		input logic signed [ttb_pkg::COORD_W-1:0] a,
		input logic signed [ttb_pkg::COORD_W-1:0] b,
		input logic signed [ttb_pkg::COORD_W-1:0] c
	);
		logic signed [ttb_pkg::COORD_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// Floor of v / TILE_SIZE, limited to the range 0 .. limit. Each tile
	// boundary is an independent constant compare; the count of passed
	// boundaries is the tile number.
	function automatic logic [CNT_W-1:0] tile_floor(
		input logic signed [ttb_pkg::COORD_W:0] v,
		input int limit
	);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int k = 1; k <= MAX_ALL; k++) begin
			if ((k <= limit) && (int'(v) >= k * TILE_SIZE)) begin
				n = n + CNT_ONE;
			end
		end
		return n;
	endfunction

	// Configuration registers.
	logic [ttb_pkg::CFG_W-1:0] across_q;
	logic [ttb_pkg::CFG_W-1:0] down_q;
	logic [CNT_W-1:0]          across_eff;
	logic [CNT_W-1:0]          down_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q <= ttb_pkg::CFG_RESET;
			down_q   <= ttb_pkg::CFG_RESET;
		end else if (cfg_write) begin
			if (cfg_index == ttb_pkg::REG_TILES_ACROSS) begin
				across_q <= cfg_data;
			end else if (cfg_index == ttb_pkg::REG_TILES_DOWN) begin
				down_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (across_q == '0) begin
			across_eff = CNT_ONE;
		end else if (int'(across_q) > MAX_TILES_ACROSS) begin
			across_eff = CNT_W'(MAX_TILES_ACROSS);
		end else begin
			across_eff = CNT_W'(across_q);
		end
		if (down_q == '0) begin
			down_eff = CNT_ONE;
		end else if (int'(down_q) > MAX_TILES_DOWN) begin
			down_eff = CNT_W'(MAX_TILES_DOWN);
		end else begin
			down_eff = CNT_W'(down_q);
		end
	end

	// Stage 1: bounding box.
	logic signed [ttb_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy;
	logic signed [ttb_pkg::COORD_W-1:0] minx_s1, miny_s1, maxx_s1, maxy_s1;

	assign ax = $signed(in_data[15:0]);
	assign ay = $signed(in_data[31:16]);
	assign bx = $signed(in_data[47:32]);
	assign by = $signed(in_data[63:48]);
	assign cx = $signed(in_data[79:64]);
	assign cy = $signed(in_data[95:80]);

	always_ff @(posedge clk) begin
		if (cmd.load_box) begin
			minx_s1 <= min3(ax, bx, cx);
			maxx_s1 <= max3(ax, bx, cx);
			miny_s1 <= min3(ay, by, cy);
			maxy_s1 <= max3(ay, by, cy);
		end
	end

	// Stage 2: tile range, clamped to the grid, and the skip decision.
	logic signed [ttb_pkg::COORD_W:0] hx_v, hy_v;
	logic [CNT_W-1:0] lo_x, lo_y, hx_raw, hy_raw, hi_x, hi_y;
	logic [CNT_W-1:0] across_m1, down_m1;
	logic             skip;
	logic [CNT_W-1:0] lo_x_s2, lo_y_s2, hi_x_s2, hi_y_s2;
	logic             skip_s2;

	always_comb begin
		hx_v      = (ttb_pkg::COORD_W + 1)'(maxx_s1) - 17'sd1;
		hy_v      = (ttb_pkg::COORD_W + 1)'(maxy_s1) - 17'sd1;
		lo_x      = tile_floor((ttb_pkg::COORD_W + 1)'(minx_s1), MAX_TILES_ACROSS);
		lo_y      = tile_floor((ttb_pkg::COORD_W + 1)'(miny_s1), MAX_TILES_DOWN);
		hx_raw    = tile_floor(hx_v, MAX_TILES_ACROSS);
		hy_raw    = tile_floor(hy_v, MAX_TILES_DOWN);
		across_m1 = across_eff - CNT_ONE;
		down_m1   = down_eff - CNT_ONE;
		hi_x      = (hx_raw > across_m1) ? across_m1 : hx_raw;
		hi_y      = (hy_raw > down_m1) ? down_m1 : hy_raw;
		skip      = (maxx_s1 <= minx_s1) || (maxy_s1 <= miny_s1) ||
		            (maxx_s1 <= 16'sd0) || (maxy_s1 <= 16'sd0) ||
		            (lo_x >= across_eff) || (lo_y >= down_eff);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_range) begin
			lo_x_s2 <= lo_x;
			lo_y_s2 <= lo_y;
			hi_x_s2 <= hi_x;
			hi_y_s2 <= hi_y;
			skip_s2 <= skip;
		end
	end

	// Triangle counter, saturating at its top.
	logic [TRIANGLE_ID_BITS-1:0] next_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
		end else if (cmd.clear_id) begin
			next_id_q <= '0;
		end else if (cmd.start && (next_id_q != ID_TOP)) begin
			next_id_q <= next_id_q + TRIANGLE_ID_BITS'(1);
		end
	end

	// Tile walker: row and column counters with the slot number kept
	// incrementally (row base plus column).
	logic [CNT_W-1:0]             row_q, col_q;
	logic [ttb_pkg::SLOT_W-1:0]   base_q, slot_q;
	logic [ttb_pkg::ID_OUT_W-1:0] id_q;
	logic [ttb_pkg::SLOT_W-1:0]   start_base;
	logic [ttb_pkg::SLOT_W-1:0]   next_base;
	logic                         row_end;

	assign start_base = ttb_pkg::SLOT_W'(lo_y_s2) * ttb_pkg::SLOT_W'(across_eff);
	assign next_base  = base_q + ttb_pkg::SLOT_W'(across_eff);
	assign row_end    = (col_q == hi_x_s2);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q  <= lo_y_s2;
			col_q  <= lo_x_s2;
			base_q <= start_base;
			slot_q <= start_base + ttb_pkg::SLOT_W'(lo_x_s2);
			id_q   <= ttb_pkg::ID_OUT_W'(next_id_q);
		end else if (cmd.step) begin
			if (row_end) begin
				row_q  <= row_q + CNT_ONE;
				col_q  <= lo_x_s2;
				base_q <= next_base;
				slot_q <= next_base + ttb_pkg::SLOT_W'(lo_x_s2);
			end else begin
				col_q  <= col_q + CNT_ONE;
				slot_q <= slot_q + ttb_pkg::SLOT_W'(1);
			end
		end
	end

	// Output register.
	logic                         out_valid_q;
	logic [ttb_pkg::SLOT_W-1:0]   out_slot_q;
	logic [ttb_pkg::ID_OUT_W-1:0] out_id_q;
	logic                         out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_slot_q <= slot_q;
			out_id_q   <= id_q;
			out_last_q <= status.last;
		end
	end

	assign status.skip     = skip_s2;
	assign status.last     = row_end && (row_q == hi_y_s2);
	assign status.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_id_q, out_slot_q};
	assign m_tlast  = out_last_q;

endmodule

// File: sv/triangle_tile_binner.sv
`timescale 1ns / 1ps

// Triangle tile binner.
// The s_* channel takes one command beat: tuser selects a bin (0) or a
// counter clear (1); tdata carries the three vertices of a bin command.
// For each bin beat the block emits one m_* beat per covered grid tile,
// row by row and left to right, with tlast on the final tile of the
// triangle. Empty boxes and boxes that lie off the grid emit nothing and
// do not use a triangle index.
// The cfg channel writes tiles_across (index 0) and tiles_down (index 1);
// cfg_ready is always high, and writes belong in idle periods.
// After a bin beat is accepted, the bounding box, the tile range, the walker
// load and the output register are loaded in turn before the first tile beat
// is valid. The tile walker produces one tile per cycle while the output
// register is free; a clear beat is taken in idle and leaves the block idle.
// The next command beat is taken as soon as the walker has handed its last
// tile to the output register, even while that beat waits on m_tready.
// When the receiver stalls, the walker holds until the output register
// frees up. Reset empties the output, sets both grid registers to 8 and
// the triangle counter to zero; no clearing pass is needed.

module triangle_tile_binner #(
	parameter int TILE_SIZE        = ttb_pkg::TILE_SIZE_DEF,
	parameter int MAX_TILES_ACROSS = ttb_pkg::MAX_TILES_ACROSS_DEF,
	parameter int MAX_TILES_DOWN   = ttb_pkg::MAX_TILES_DOWN_DEF,
	parameter int TRIANGLE_ID_BITS = ttb_pkg::TRIANGLE_ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
	input  logic [ttb_pkg::IN_TDATA_W-1:0]  s_tdata,
	// command
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tile_slot, triangle_id, two zero bits
	output logic [ttb_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ttb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ttb_pkg::CFG_W-1:0]       cfg_data
);

	ttb_pkg::dp_cmd_t    cmd;
	ttb_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	ttb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser),
		.in_ready   (s_tready),
		.status     (status),
		.cmd        (cmd)
	);

	ttb_datapath #(
		.TILE_SIZE        (TILE_SIZE),
		.MAX_TILES_ACROSS (MAX_TILES_ACROSS),
		.MAX_TILES_DOWN   (MAX_TILES_DOWN),
		.TRIANGLE_ID_BITS (TRIANGLE_ID_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// The walker only emits into a free output register.
	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> status.out_free)
		else $error("tile emitted into a full output register");

	// No command beat is taken while tiles are still being walked.
	a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.step && !cmd.start && !cmd.load_range)
		else $error("command accepted while a triangle is in flight");

	// A captured bounding box is always followed by a range capture.
	a_box_then_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_box |=> cmd.load_range)
		else $error("tile range not computed after bounding box");

endmodule

// File: dv/tile_bin_checker.sv
`timescale 1ns / 1ps

// Watches the command, configuration and tile channels of the binner. It keeps its own
// copy of the grid registers and the triangle counter, works out the tile beats that
// each accepted command beat must produce, and compares every tile beat with the
// oldest one still owed.
module tile_bin_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [ttb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [ttb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            m_tlast,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [ttb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ttb_pkg::CFG_W-1:0]       cfg_data,
	output int unsigned                     tiles_pending,
	output int unsigned                     fail_count
);

	localparam int              TILE         = ttb_pkg::TILE_SIZE_DEF;
	localparam longint unsigned ID_TOP       =
		(64'd1 << ttb_pkg::TRIANGLE_ID_BITS_DEF) - 64'd1;
	localparam int unsigned     REPORT_LIMIT = 10;

	typedef struct packed {
		logic [ttb_pkg::SLOT_W-1:0]   slot;
		logic [ttb_pkg::ID_OUT_W-1:0] id;
		logic                         last;
	} tile_beat_t;

	tile_beat_t                expected_tiles[$];
	logic [ttb_pkg::CFG_W-1:0] grid_across    = ttb_pkg::CFG_RESET;
	logic [ttb_pkg::CFG_W-1:0] grid_down      = ttb_pkg::CFG_RESET;
	longint unsigned           next_id        = 0;
	int unsigned               pending_count  = 0;
	int unsigned               mismatch_count = 0;

	assign tiles_pending = pending_count;
	assign fail_count    = mismatch_count;

	// Floor division, so that pixels -1 .. -TILE land in tile -1.
	function automatic int tile_of(input int px);
		if (px >= 0) begin
			return px / TILE;
		end
		return -((-px + TILE - 1) / TILE);
	endfunction

	// A register value of zero acts as one; anything above the maximum acts as the maximum.
	function automatic int grid_extent(input logic [ttb_pkg::CFG_W-1:0] reg_value,
		input int max_value);
		int v;
		v = int'(reg_value);
		if (v < 1) begin
			v = 1;
		end
		if (v > max_value) begin
			v = max_value;
		end
		return v;
	endfunction

	task automatic predict_tiles(input logic cmd,
		input logic [ttb_pkg::IN_TDATA_W-1:0] verts);
		int         k, r, c, px, py;
		int         min_x, max_x, min_y, max_y;
		int         lo_col, lo_row, hi_col, hi_row, across, down;
		tile_beat_t beat;
		if (cmd == ttb_pkg::CMD_CLEAR) begin
			next_id = 0;
			return;
		end
		for (k = 0; k < 3; k++) begin
			px = int'($signed(verts[2*k*ttb_pkg::COORD_W +: ttb_pkg::COORD_W]));
			py = int'($signed(verts[(2*k+1)*ttb_pkg::COORD_W +: ttb_pkg::COORD_W]));
			if (k == 0 || px < min_x) min_x = px;
			if (k == 0 || px > max_x) max_x = px;
			if (k == 0 || py < min_y) min_y = py;
			if (k == 0 || py > max_y) max_y = py;
		end
		// The maximum corner is exclusive, so a box of zero width or height is empty.
		if (max_x <= min_x || max_y <= min_y) begin
			return;
		end
		across = grid_extent(grid_across, ttb_pkg::MAX_TILES_ACROSS_DEF);
		down   = grid_extent(grid_down, ttb_pkg::MAX_TILES_DOWN_DEF);
		lo_col = tile_of(min_x);
		lo_row = tile_of(min_y);
		hi_col = tile_of(max_x - 1);
		hi_row = tile_of(max_y - 1);
		// Boxes wholly off the grid are dropped before clamping and use no index.
		if (hi_col < 0 || hi_row < 0 || lo_col >= across || lo_row >= down) begin
			return;
		end
		if (lo_col < 0) lo_col = 0;
		if (lo_row < 0) lo_row = 0;
		if (hi_col > across - 1) hi_col = across - 1;
		if (hi_row > down - 1) hi_row = down - 1;
		beat.id = next_id[ttb_pkg::ID_OUT_W-1:0];
		if (next_id < ID_TOP) begin
			next_id = next_id + 1;
		end
		for (r = lo_row; r <= hi_row; r++) begin
			for (c = lo_col; c <= hi_col; c++) begin
				beat.slot = ttb_pkg::SLOT_W'(r * across + c);
				beat.last = (r == hi_row && c == hi_col);
				expected_tiles.insert(expected_tiles.size(), beat);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		tile_beat_t seen;
		tile_beat_t want;
		if (!arst_n) begin
			grid_across = ttb_pkg::CFG_RESET;
			grid_down   = ttb_pkg::CFG_RESET;
			next_id     = 0;
			expected_tiles.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ttb_pkg::REG_TILES_ACROSS: grid_across = cfg_data;
					ttb_pkg::REG_TILES_DOWN:   grid_down   = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				seen.slot = m_tdata[ttb_pkg::SLOT_W-1:0];
				seen.id   = m_tdata[ttb_pkg::SLOT_W +: ttb_pkg::ID_OUT_W];
				seen.last = m_tlast;
				if (expected_tiles.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: tile beat with none owed: slot %0d id %0d last %0b",
							$realtime, seen.slot, seen.id, seen.last);
					end
				end else begin
					want = expected_tiles.pop_front();
					if (seen !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display({"%0t: tile beat mismatch: expected slot %0d id %0d",
								" last %0b, got slot %0d id %0d last %0b"},
								$realtime, want.slot, want.id, want.last,
								seen.slot, seen.id, seen.last);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_tiles(s_tuser, s_tdata);
			end
		end
		pending_count = expected_tiles.size();
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Top of the binner testbench. It drives command beats and grid register writes into
// the block, throttles the tile channel, and gives the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module tb;

	// How hard a side idles between beats.
	typedef enum int {
		IDLE_NONE,
		IDLE_LIGHT,
		IDLE_FULL
	} idle_mode_t;

	// Covers the box and range states of a bin beat that turns out to produce no
	// tiles, so that the pipeline has run dry.
	localparam int DRAIN_CYCLES = 8;
	// The longest correct stretch without any beat is a receiver stall plus the
	// pipeline, or a drain pause; this is many times that.
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 280;
	// Single-tile triangles sent back to back with no idling on either side.
	localparam int FILL_ITEMS   = 20;
	localparam int GRID_PX      = ttb_pkg::MAX_TILES_ACROSS_DEF * ttb_pkg::TILE_SIZE_DEF;

	logic                            clk    = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid;
	logic                            s_tready;
	// vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
	logic [ttb_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                            s_tuser;   // command
	logic                            m_tvalid;
	logic                            m_tready;
	logic [ttb_pkg::OUT_TDATA_W-1:0] m_tdata;   // tile_slot, triangle_id, two zero bits
	logic                            m_tlast;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [ttb_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ttb_pkg::CFG_W-1:0]       cfg_data;

	int unsigned tiles_pending;
	int unsigned fail_count;

	idle_mode_t s_mode       = IDLE_FULL;
	idle_mode_t m_mode       = IDLE_FULL;
	logic       m_beat_taken = 1'b0;
	int         m_hold       = 0;
	int         quiet_cycles = 0;

	triangle_tile_binner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tile_bin_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.tiles_pending (tiles_pending),
		.fail_count    (fail_count)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Number of idle cycles before the next beat on one side.
	function automatic int idle_cycles(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:  return 0;
			IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
			default:    return int'($urandom_range(0, 17));
		endcase
	endfunction

	// Grid register values lean toward the extremes, including the ones that are
	// out of range and get clamped by the block.
	function automatic logic [ttb_pkg::CFG_W-1:0] grid_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return ttb_pkg::CFG_W'(1);
			3:       return ttb_pkg::CFG_RESET;
			default: return ttb_pkg::CFG_W'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [ttb_pkg::IN_TDATA_W-1:0] pack_verts(input int ax, input int ay,
		input int bx, input int by, input int cx, input int cy);
		return {ttb_pkg::COORD_W'(cy), ttb_pkg::COORD_W'(cx), ttb_pkg::COORD_W'(by),
			ttb_pkg::COORD_W'(bx), ttb_pkg::COORD_W'(ay), ttb_pkg::COORD_W'(ax)};
	endfunction

	function automatic logic [ttb_pkg::IN_TDATA_W-1:0] noise();
		return ttb_pkg::IN_TDATA_W'({$urandom(), $urandom(), $urandom()});
	endfunction

	// The receiver drops tready for a random number of cycles before every tile beat.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			m_beat_taken = 1'b1;
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (m_beat_taken) begin
				m_beat_taken = 1'b0;
				m_hold = idle_cycles(m_mode);
			end
			if (m_hold > 0) begin
				m_tready <= 1'b0;
				m_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// The watchdog ends a run that has gone quiet on all three channels.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Presents one command beat after a random gap and returns at the falling edge
	// after it was taken. tvalid stays high so that a following beat can go back to
	// back; whoever stops sending lowers it.
	task automatic send_beat(input logic cmd, input logic [ttb_pkg::IN_TDATA_W-1:0] verts);
		int gap;
		gap = idle_cycles(s_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= verts;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stops sending and waits until every owed tile beat has arrived, then lets the
	// pipeline run dry in case the last command produced no tiles at all.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tiles_pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes both grid registers while the block is idle, back to back on the
	// configuration channel.
	task automatic set_grid(input logic [ttb_pkg::CFG_W-1:0] across,
		input logic [ttb_pkg::CFG_W-1:0] down);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= ttb_pkg::REG_TILES_ACROSS;
		cfg_data  <= across;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_index <= ttb_pkg::REG_TILES_DOWN;
		cfg_data  <= down;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random command. Most are triangles around the grid with random size, so
	// that coverage, clamping and off-grid drops all happen; the rest are clears,
	// boxes of zero width or height, and full-range noise.
	task automatic send_random_item();
		int pick, span, base_x, base_y, k;
		int vx[3];
		int vy[3];
		pick = int'($urandom_range(0, 99));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: span = 24;
			6, 7, 8:          span = 64;
			default:          span = 2 * GRID_PX;
		endcase
		base_x = int'($urandom_range(0, GRID_PX + 96)) - 48;
		base_y = int'($urandom_range(0, GRID_PX + 96)) - 48;
		for (k = 0; k < 3; k++) begin
			vx[k] = base_x + int'($urandom_range(0, span));
			vy[k] = base_y + int'($urandom_range(0, span));
		end
		if (pick < 5) begin
			send_beat(ttb_pkg::CMD_CLEAR, noise());
		end else if (pick < 15) begin
			send_beat(ttb_pkg::CMD_BIN, noise());
		end else begin
			if (pick < 20) begin
				vx[1] = vx[0];
				vx[2] = vx[0];
			end else if (pick < 25) begin
				vy[1] = vy[0];
				vy[2] = vy[0];
			end
			send_beat(ttb_pkg::CMD_BIN, pack_verts(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]));
		end
	endtask

	initial begin
		int n, ox, oy, x0, y0;
		s_tvalid  <= 1'b0;
		s_tuser   <= ttb_pkg::CMD_BIN;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= ttb_pkg::REG_TILES_ACROSS;
		cfg_data  <= ttb_pkg::CFG_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats on the reset grid of 8 by 8 tiles.
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, 0, GRID_PX, 0, 0, GRID_PX));  // whole grid
		// coordinate extremes
		send_beat(ttb_pkg::CMD_BIN, pack_verts(-32768, -32768, 32767, 32767, 0, 0));
		send_beat(ttb_pkg::CMD_BIN,
			pack_verts(-32768, -32768, -32768, -32768, -32768, -32768));
		send_beat(ttb_pkg::CMD_BIN, pack_verts(32767, 32767, 32767, 32767, 32767, 32767));
		send_beat(ttb_pkg::CMD_BIN, pack_verts(5, 5, 6, 5, 5, 6));              // one pixel
		send_beat(ttb_pkg::CMD_BIN, pack_verts(16, 16, 32, 16, 16, 32));  // exclusive max edge
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, 0, 17, 0, 0, 17));       // one pixel over
		send_beat(ttb_pkg::CMD_BIN, pack_verts(10, 0, 10, 20, 10, 40));    // zero width
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, 7, 30, 7, 60, 7));       // zero height
		send_beat(ttb_pkg::CMD_BIN, pack_verts(-50, 0, -1, 10, -20, 30));  // off the left
		send_beat(ttb_pkg::CMD_BIN,
			pack_verts(GRID_PX, 0, GRID_PX + 12, 10, GRID_PX + 2, 20));
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, -40, 50, -1, 20, -30));  // off the top
		send_beat(ttb_pkg::CMD_BIN,
			pack_verts(0, GRID_PX, 30, GRID_PX + 72, 60, GRID_PX + 22));
		send_beat(ttb_pkg::CMD_BIN, pack_verts(-100, -100, 20, 5, 5, 20)); // clamped low side
		send_beat(ttb_pkg::CMD_BIN, pack_verts(-16, 0, 0, 0, -8, 16));     // max x exactly zero
		send_beat(ttb_pkg::CMD_CLEAR, noise());
		send_beat(ttb_pkg::CMD_BIN, pack_verts(100, 100, 127, 110, 110, 127)); // index zero again

		// The smallest grid, then out-of-range register values that clamp, then grids of 3 by 8 and 8 by 1 tiles.
		set_grid(ttb_pkg::CFG_W'(1), ttb_pkg::CFG_W'(1));
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, 0, GRID_PX, 0, 0, GRID_PX));
		send_beat(ttb_pkg::CMD_BIN, pack_verts(16, 0, 40, 0, 16, 10));   // beyond column zero
		set_grid('0, '0);
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, 0, GRID_PX, 0, 0, GRID_PX));
		set_grid('1, '1);
		send_beat(ttb_pkg::CMD_BIN, pack_verts(-32768, -32768, 32767, 32767, 0, 0));
		set_grid(ttb_pkg::CFG_W'(3), ttb_pkg::CFG_RESET);
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, 0, GRID_PX, 0, 0, GRID_PX));
		set_grid(ttb_pkg::CFG_RESET, ttb_pkg::CFG_W'(1));
		send_beat(ttb_pkg::CMD_BIN, pack_verts(0, 0, GRID_PX, 0, 0, GRID_PX));

		// Random commands. Idling styles change every 25 beats so that there are long
		// stretches without gaps as well as heavy throttling; the grid changes every
		// 35 beats, and now and then the sender waits for the block to run empty.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 25 == 0) begin
				s_mode = idle_mode_t'($urandom_range(0, 2));
				m_mode = idle_mode_t'($urandom_range(0, 2));
			end
			if (n % 35 == 34) begin
				set_grid(grid_value(), grid_value());
			end else if ($urandom_range(0, 29) == 0) begin
				drain();
			end
			send_random_item();
		end

		// A burst of small triangles at full rate from a cleared counter, then more
		// random commands around one more clear.
		set_grid(ttb_pkg::CFG_RESET, ttb_pkg::CFG_RESET);
		s_mode = IDLE_NONE;
		m_mode = IDLE_NONE;
		send_beat(ttb_pkg::CMD_CLEAR, '0);
		for (n = 0; n < FILL_ITEMS; n++) begin
			ox = int'($urandom_range(0, ttb_pkg::TILE_SIZE_DEF - 2));
			oy = int'($urandom_range(0, ttb_pkg::TILE_SIZE_DEF - 2));
			x0 = int'($urandom_range(0, ttb_pkg::MAX_TILES_ACROSS_DEF - 1)) *
				ttb_pkg::TILE_SIZE_DEF + ox;
			y0 = int'($urandom_range(0, ttb_pkg::MAX_TILES_DOWN_DEF - 1)) *
				ttb_pkg::TILE_SIZE_DEF + oy;
			send_beat(ttb_pkg::CMD_BIN, pack_verts(x0, y0,
				x0 + int'($urandom_range(1, ttb_pkg::TILE_SIZE_DEF - ox)), y0,
				x0, y0 + int'($urandom_range(1, ttb_pkg::TILE_SIZE_DEF - oy))));
		end
		s_mode = IDLE_FULL;
		m_mode = IDLE_LIGHT;
		for (n = 0; n < 12; n++) begin
			send_random_item();
		end
		send_beat(ttb_pkg::CMD_CLEAR, noise());
		for (n = 0; n < 10; n++) begin
			send_random_item();
		end

		drain();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
